// File: rtl/frustum_sphere_cull_unit_defines.svh
// Assertion macros for the frustum sphere cull unit.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef FRUSTUM_SPHERE_CULL_UNIT_DEFINES_SVH
`define FRUSTUM_SPHERE_CULL_UNIT_DEFINES_SVH
`ifndef SYNTH
`define FSC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("frustum sphere cull assertion failed");
`define FSC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frustum sphere cull assertion failed");
`else
`define FSC_ASSERT(name, prop)
`define FSC_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// File: rtl/fsc_pkg.sv
// Shared types, constants and plane tables of the frustum sphere cull unit.
// No dependencies.
package fsc_pkg;

  localparam int PLANE_COUNT  = 6;
  localparam int CELL_STAGES  = 5;
  localparam int LATENCY      = PLANE_COUNT * CELL_STAGES;
  localparam int RESULT_DEPTH = 32;

  localparam int COL_W = 64;
  localparam int POS_W = 32;
  localparam int RAD_W = 31;

  typedef enum logic [1:0] {
    VERDICT_VISIBLE  = 2'd0,
    VERDICT_REJECTED = 2'd1,
    VERDICT_OUTSIDE  = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    REG_COL0    = 3'd0,
    REG_COL1    = 3'd1,
    REG_COL2    = 3'd2,
    REG_COL3    = 3'd3,
    REG_CULL_EN = 3'd4,
    REG_RADIUS  = 3'd5
  } cfg_idx_e;

  typedef logic [3:0][COL_W-1:0] matrix_t;

  typedef struct packed {
    logic                    valid;
    logic                    rejected;
    logic                    cull_en;
    logic                    culled;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } item_t;

  // Bit p set: plane p adds column 3; plane p subtracts the other column.
  localparam logic [PLANE_COUNT-1:0] PLANE_USES_C3 = 6'b101111;
  localparam logic [PLANE_COUNT-1:0] PLANE_NEGATE  = 6'b101010;

  function automatic logic [1:0] plane_col(input int p);
    logic [1:0] c;
    case (p)
      0, 1:    c = 2'd0;
      2, 3:    c = 2'd1;
      default: c = 2'd2;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/frustum_sphere_cull_unit.sv
// One object per cycle while fewer than ResultDepth objects are in flight.
// Full rate is held by a chain of six plane cells of five stages each; a
// result queue of ResultDepth entries lets input continue while output stalls.
// Reset: columns zero, culling enabled, radius 5.0, pipeline and queue empty.
// Top level of the frustum sphere cull unit; depends on fsc_pkg,
// fsc_plane_cell, fsc_result_fifo and frustum_sphere_cull_unit_defines.svh.
`include "frustum_sphere_cull_unit_defines.svh"
module frustum_sphere_cull_unit import fsc_pkg::*; #(
  parameter int ResultDepth = RESULT_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // object_active, object_shown, pos_x, pos_y, pos_z, zero padding
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pass, verdict, zero padding
  output logic [7:0]   m_axis_tdata
);

  localparam int CntW = $clog2(ResultDepth + 1);

  matrix_t          col_q;
  logic             cull_en_q;
  logic [RAD_W-1:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      cull_en_q <= 1'b1;
      radius_q  <= RAD_W'(327680);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COL0:    col_q[0]  <= cfg_data_i;
        REG_COL1:    col_q[1]  <= cfg_data_i;
        REG_COL2:    col_q[2]  <= cfg_data_i;
        REG_COL3:    col_q[3]  <= cfg_data_i;
        REG_CULL_EN: cull_en_q <= cfg_data_i[0];
        REG_RADIUS:  radius_q  <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  logic            in_acc, out_acc;
  logic [CntW-1:0] inflight_q;

  assign s_axis_tready = inflight_q != CntW'(ResultDepth);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + CntW'(in_acc) - CntW'(out_acc);
    end
  end

  item_t chain [PLANE_COUNT + 1];

  always_comb begin
    chain[0]          = '0;
    chain[0].valid    = in_acc;
    chain[0].rejected = !(s_axis_tdata[0] && s_axis_tdata[1]);
    chain[0].cull_en  = cull_en_q;
    chain[0].x        = s_axis_tdata[33:2];
    chain[0].y        = s_axis_tdata[65:34];
    chain[0].z        = s_axis_tdata[97:66];
  end

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cell
    fsc_plane_cell #(
      .PlaneIdx(p)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .matrix_i(col_q),
      .radius_i(radius_q),
      .item_i  (chain[p]),
      .item_o  (chain[p+1])
    );
  end

  item_t    last;
  verdict_e verdict;
  logic     pass;
  logic [2:0] res_data;
  logic     res_pass_ok;

  assign last = chain[PLANE_COUNT];

  always_comb begin
    if (last.rejected) begin
      verdict = VERDICT_REJECTED;
    end else if (last.cull_en && last.culled) begin
      verdict = VERDICT_OUTSIDE;
    end else begin
      verdict = VERDICT_VISIBLE;
    end
  end

  assign pass = verdict == VERDICT_VISIBLE;

  fsc_result_fifo #(
    .Depth(ResultDepth),
    .Width(3)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (last.valid),
    .wr_data_i  ({verdict, pass}),
    .rd_en_i    (out_acc),
    .not_empty_o(m_axis_tvalid),
    .rd_data_o  (res_data)
  );

  assign m_axis_tdata = {5'b00000, res_data};
  assign res_pass_ok  = res_data[0] == (res_data[2:1] == VERDICT_VISIBLE);

  `FSC_ASSERT(a_inflight_bound, inflight_q <= CntW'(ResultDepth))
  `FSC_ASSERT(a_pass_matches_verdict, !m_axis_tvalid || res_pass_ok)
  `FSC_ASSERT_NEXT(a_accept_counted, in_acc && !out_acc, inflight_q != '0)
  `FSC_ASSERT(a_output_has_item, !m_axis_tvalid || (inflight_q != '0))

endmodule

// File: rtl/fsc_plane_cell.sv
// One cell of the culling chain: tests the passing object against one plane.
// Depends on fsc_pkg.
module fsc_plane_cell import fsc_pkg::*; #(
  parameter int PlaneIdx = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  matrix_t          matrix_i,
  input  logic [RAD_W-1:0] radius_i,
  input  item_t            item_i,
  output item_t            item_o
);

  localparam logic [1:0] OtherCol = plane_col(PlaneIdx);
  localparam logic       UsesC3   = PLANE_USES_C3[PlaneIdx];
  localparam logic       Negate   = PLANE_NEGATE[PlaneIdx];

  logic signed [17:0] k [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      logic signed [17:0] eo;
      logic signed [17:0] e3;
      eo = 18'(signed'(matrix_i[OtherCol][16*r +: 16]));
      e3 = 18'(signed'(matrix_i[3][16*r +: 16]));
      k[r] = (Negate ? -eo : eo) + (UsesC3 ? e3 : 18'sd0);
    end
  end

  // Stage 1: products.
  item_t              it1_q;
  logic signed [49:0] px_q, py_q, pz_q;
  logic signed [17:0] k3_q;
  logic [35:0]        sq0_q, sq1_q, sq2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it1_q <= '0;
    end else begin
      it1_q <= item_i;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q  <= k[0] * item_i.x;
    py_q  <= k[1] * item_i.y;
    pz_q  <= k[2] * item_i.z;
    k3_q  <= k[3];
    sq0_q <= 36'(k[0] * k[0]);
    sq1_q <= 36'(k[1] * k[1]);
    sq2_q <= 36'(k[2] * k[2]);
  end

  // Stage 2: distance, squared length, squared radius.
  logic signed [51:0] dist_d;
  logic [34:0]        l2_d;
  logic signed [33:0] w_scaled;
  logic signed [33:0] neg_rad;

  assign dist_d   = 52'(px_q) + 52'(py_q) + 52'(pz_q) + (52'(k3_q) <<< 16);
  assign l2_d     = 35'(sq0_q) + 35'(sq1_q) + 35'(sq2_q);
  assign w_scaled = 34'(k3_q) <<< 8;
  assign neg_rad  = -$signed({3'b000, radius_i});

  item_t       it2_q;
  logic        neg2_q, flat2_q, flat_cull2_q;
  logic [49:0] mag2_q;
  logic [34:0] l2_2_q;
  logic [61:0] r2_2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it2_q <= '0;
    end else begin
      it2_q <= it1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    neg2_q       <= dist_d < 0;
    flat2_q      <= l2_d == '0;
    flat_cull2_q <= w_scaled < neg_rad;
    mag2_q       <= 50'(-dist_d);
    l2_2_q       <= l2_d;
    r2_2_q       <= radius_i * radius_i;
  end

  // Stage 3: partial products of both squares.
  item_t       it3_q;
  logic        neg3_q, flat3_q, flat_cull3_q;
  logic [49:0] mhh_q, mhl_q, mll_q;
  logic [65:0] rlo_q, rhi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it3_q <= '0;
    end else begin
      it3_q <= it2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    neg3_q       <= neg2_q;
    flat3_q      <= flat2_q;
    flat_cull3_q <= flat_cull2_q;
    mhh_q        <= mag2_q[49:25] * mag2_q[49:25];
    mhl_q        <= mag2_q[49:25] * mag2_q[24:0];
    mll_q        <= mag2_q[24:0] * mag2_q[24:0];
    rlo_q        <= r2_2_q[30:0] * l2_2_q;
    rhi_q        <= r2_2_q[61:31] * l2_2_q;
  end

  // Stage 4: sums.
  item_t        it4_q;
  logic         neg4_q, flat4_q, flat_cull4_q;
  logic [99:0]  msq_q, rsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it4_q <= '0;
    end else begin
      it4_q <= it3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    neg4_q       <= neg3_q;
    flat4_q      <= flat3_q;
    flat_cull4_q <= flat_cull3_q;
    msq_q        <= (100'(mhh_q) << 50) + (100'(mhl_q) << 26) + 100'(mll_q);
    rsq_q        <= (100'(rhi_q) << 31) + 100'(rlo_q);
  end

  // Stage 5: compare and merge into the running verdict.
  logic  hit;
  item_t it5_d, it5_q;

  assign hit = flat4_q ? flat_cull4_q : (neg4_q && (msq_q > rsq_q));

  always_comb begin
    it5_d        = it4_q;
    it5_d.culled = it4_q.culled | hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it5_q <= '0;
    end else begin
      it5_q <= it5_d;
    end
  end

  assign item_o = it5_q;

endmodule

// File: rtl/fsc_result_fifo.sv
// Result queue that decouples the culling chain from the output stream.
// No dependencies.
module fsc_result_fifo #(
  parameter int Depth = 32,
  parameter int Width = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  output logic             not_empty_o,
  output logic [Width-1:0] rd_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(wr_en_i) - CntW'(rd_en_i);
    end
  end

  assign not_empty_o = cnt_q != '0;
  assign rd_data_o   = mem_q[rd_ptr_q];

endmodule

// File: sim/frustum_sphere_cull_checker.sv
`timescale 1ns / 100ps
// Checker for the frustum sphere cull unit: follows register writes, predicts
// the result of each input transaction and compares it with the output stream.
// Depends on fsc_pkg.
module frustum_sphere_cull_checker import fsc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [7:0]   m_axis_tdata,
  output int           error_count,
  output int           pending
);

  typedef struct packed {
    logic     pass;
    verdict_e verdict;
  } outcome_t;

  localparam int EXP_DEPTH = 4096;

  logic [3:0][63:0] columns;
  logic             cull_on;
  logic [30:0]      radius;
  outcome_t         expected_mem [EXP_DEPTH];
  int               wr_count, rd_count;

  function automatic logic signed [63:0] entry(int col, int row);
    return 64'($signed(columns[col][row*16 +: 16]));
  endfunction

  function automatic bit plane_rejects(int p, logic signed [63:0] x, logic signed [63:0] y,
                                       logic signed [63:0] z);
    logic signed [63:0] k[4];
    logic signed [63:0] d;
    logic [127:0]       l2, mag, dd, rr;
    int                 other;
    bit                 negate, add_w;
    other  = p / 2;
    negate = (p % 2) == 1;
    add_w  = p != 4;
    for (int r = 0; r < 4; r++) begin
      k[r] = negate ? -entry(other, r) : entry(other, r);
      if (add_w) k[r] = k[r] + entry(3, r);
    end
    d  = k[0] * x + k[1] * y + k[2] * z + k[3] * 64'sd65536;
    l2 = 128'(k[0] * k[0] + k[1] * k[1] + k[2] * k[2]);
    if (l2 == 0) return (k[3] * 64'sd256) < -$signed({33'd0, radius});
    if (d >= 0) return 1'b0;
    mag = 128'(-d);
    dd  = mag * mag;
    rr  = 128'(radius) * 128'(radius) * l2;
    return dd > rr;
  endfunction

  function automatic outcome_t predict_outcome(logic [103:0] data);
    outcome_t o;
    o.pass    = 1'b1;
    o.verdict = VERDICT_VISIBLE;
    if (!data[0] || !data[1]) begin
      o.pass    = 1'b0;
      o.verdict = VERDICT_REJECTED;
    end else if (cull_on) begin
      for (int p = 0; p < PLANE_COUNT; p++)
        if (plane_rejects(p, 64'($signed(data[33:2])), 64'($signed(data[65:34])),
                          64'($signed(data[97:66])))) begin
          o.pass    = 1'b0;
          o.verdict = VERDICT_OUTSIDE;
        end
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    int       errs;
    errs = 0;
    if (!rst_ni) begin
      columns     <= '0;
      cull_on     <= 1'b1;
      radius      <= 31'd327680;
      error_count <= 0;
      pending     <= 0;
      wr_count    = 0;
      rd_count    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_COL0, REG_COL1, REG_COL2, REG_COL3: columns[cfg_idx_i[1:0]] <= cfg_data_i;
          REG_CULL_EN: cull_on <= cfg_data_i[0];
          REG_RADIUS:  radius  <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_mem[wr_count % EXP_DEPTH] = predict_outcome(s_axis_tdata);
        wr_count = wr_count + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (wr_count == rd_count) begin
          $error("result transaction with no expectation waiting");
          errs = errs + 1;
        end else begin
          want     = expected_mem[rd_count % EXP_DEPTH];
          rd_count = rd_count + 1;
          if (m_axis_tdata[0] !== want.pass) begin
            $error("pass: expected %0d, actual %0d", want.pass, m_axis_tdata[0]);
            errs = errs + 1;
          end
          if (m_axis_tdata[2:1] !== want.verdict) begin
            $error("verdict: expected %0d, actual %0d", want.verdict, m_axis_tdata[2:1]);
            errs = errs + 1;
          end
        end
      end
      error_count <= error_count + errs;
      pending     <= wr_count - rd_count;
    end
  end

endmodule

// File: sim/frustum_sphere_cull_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top of the frustum sphere cull unit: clock, reset, register
// writes, object stimulus and verdict. Depends on fsc_pkg and the checker.
module frustum_sphere_cull_unit_tb import fsc_pkg::*;;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic [15:0] ONE_Q88 = 16'h0100;
  localparam int PHASES = 8;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [63:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;
  int           error_count, pending;
  int           send_idle_pct = 0, recv_idle_pct = 0;
  logic         hold_req = 1'b0, hold_done = 1'b0;
  int           hold_left = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  frustum_sphere_cull_unit dut (.*);
  frustum_sphere_cull_checker checker_i (.*);

  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done     <= 1'b1;
      hold_left     <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic send_object(logic active, logic shown, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, z, y, x, shown, active};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
      default: return 32'($signed($urandom_range(2 * 65536 * 8)) - 65536 * 8);
    endcase
  endfunction

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(5))
      0:       return 16'($urandom());
      1:       return 16'h0000;
      2:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(1024)) - 512);
    endcase
  endfunction

  task automatic load_random_config(int phase);
    logic [63:0] col;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) col[r*16 +: 16] = rand_entry();
      if (phase % 3 == 0) col = '0;
      if (phase % 3 == 0) col[c*16 +: 16] = ONE_Q88;
      write_reg(cfg_idx_e'(c), col);
    end
    write_reg(REG_CULL_EN, 64'((phase % 4) != 3));
    case (phase % 5)
      0:       write_reg(REG_RADIUS, 64'd0);
      1:       write_reg(REG_RADIUS, 64'h7FFF_FFFF);
      2:       write_reg(REG_RADIUS, 64'hFFFF_FFFF_FFFF_FFFF);
      default: write_reg(REG_RADIUS, 64'($urandom_range(65536 * 8)));
    endcase
    end_writes();
  endtask

  initial begin
    #(12ns * 400000);
    $display("** frustum_sphere_cull_unit: FAILED **");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: all planes degenerate with zero w, nothing culled.
    send_object(1'b1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_object(1'b0, 1'b1, 32'h0, 32'h0, 32'h0);
    send_object(1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_object(1'b0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    drain();

    // Unit matrix; boundaries at plus and minus one, radius zero and five.
    write_reg(REG_COL0, 64'(ONE_Q88));
    write_reg(REG_COL1, 64'(ONE_Q88) << 16);
    write_reg(REG_COL2, 64'(ONE_Q88) << 32);
    write_reg(REG_COL3, 64'(ONE_Q88) << 48);
    write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_RADIUS, 64'd0);
    end_writes();
    send_object(1'b1, 1'b1, 32'h0, 32'h0, 32'h0);
    send_object(1'b1, 1'b1, -32'sd65536, 32'h0, 32'h8000);
    send_object(1'b1, 1'b1, -32'sd65537, 32'h0, 32'h8000);
    send_object(1'b1, 1'b1, 32'h0, 32'h0, -32'sd1);
    send_object(1'b1, 1'b1, 32'h0, 32'h0, 32'h0001_0001);
    send_object(1'b1, 1'b1, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send_object(1'b1, 1'b1, 32'h0, 32'h8000_0000, 32'h0);
    drain();
    write_reg(REG_RADIUS, 64'd327680);
    end_writes();
    send_object(1'b1, 1'b1, -32'sd393216, 32'h0, 32'h8000);
    send_object(1'b1, 1'b1, -32'sd393217, 32'h0, 32'h8000);
    send_object(1'b1, 1'b1, 32'h0, 32'h0, -32'sd327680);
    drain();

    // Degenerate planes with negative w cull everything, unless culling is off.
    write_reg(REG_COL0, 64'h0);
    write_reg(REG_COL1, 64'h0);
    write_reg(REG_COL2, 64'h0);
    write_reg(REG_COL3, 64'hFFFF_0000_0000_0000);
    write_reg(REG_RADIUS, 64'd0);
    end_writes();
    send_object(1'b1, 1'b1, 32'h0, 32'h0, 32'h0);
    send_object(1'b0, 1'b1, 32'h0, 32'h0, 32'h0);
    drain();
    write_reg(REG_CULL_EN, 64'd0);
    end_writes();
    send_object(1'b1, 1'b1, 32'h0, 32'h0, 32'h0);
    send_object(1'b1, 1'b0, 32'h0, 32'h0, 32'h0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      load_random_config(ph);
      for (int n = 0; n < 195; n++) begin
        case ((ph * 195 + n) * 3 / (PHASES * 195))
          0:       begin send_idle_pct = 27; recv_idle_pct = 84; end
          1:       begin send_idle_pct = 84; recv_idle_pct = 27; end
          default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        endcase
        if (ph == PHASES - 1 && n == 10) hold_req <= 1'b1;
        if (n % 64 == 63) drain();
        send_object($urandom_range(7) != 0, $urandom_range(7) != 0,
                    rand_coord(), rand_coord(), rand_coord());
      end
      drain();
    end

    if (error_count == 0 && pending == 0) begin
      $display("** frustum_sphere_cull_unit: PASSED **");
    end else begin
      $display("** frustum_sphere_cull_unit: FAILED **");
    end
    $finish;
  end

endmodule
